// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/fbd_pkg.sv =====
// Shared constants and types for the fractional baud divisor search.
package fbd_pkg;

  localparam int unsigned MulMax    = 15;
  localparam int unsigned MulW      = 4;
  localparam int unsigned BaudW     = 24;
  localparam int unsigned SysClkW   = 32;
  localparam int unsigned PclkW     = SysClkW - 2;
  localparam int unsigned DlW       = 17;
  localparam int unsigned DivNumW   = 64;
  localparam int unsigned DivDenW   = 32;
  localparam int unsigned DivCntW   = $clog2(DivNumW);
  localparam int unsigned PctLimit  = 3;
  localparam int unsigned PctScale  = 100;
  localparam int unsigned FracShift = 28;
  localparam int unsigned DlMax     = 65536;

  localparam logic [SysClkW-1:0] SysClkReset = 32'd100000000;
  localparam logic [31:0]        HalfQ32     = 32'h8000_0000;
  localparam logic [31:0]        ErrInit     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/fbd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module fbd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbd_pkg::div_req_t req_i,
  output fbd_pkg::div_rsp_t rsp_o
);
  import fbd_pkg::*;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e         state_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic               done_q;

  logic [DivDenW:0]   rem_sh;
  logic               ge;
  logic [DivDenW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DivNumW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DIV_IDLE: begin
          if (req_i.start) begin
            quo_q   <= req_i.dividend;
            den_q   <= req_i.divisor;
            rem_q   <= '0;
            cnt_q   <= DivCntW'(DivNumW - 1);
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          quo_q <= {quo_q[DivNumW-2:0], ge};
          rem_q <= ge ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/fractional_baud_divisor_search_top.sv =====
// Top level of the fractional baud divisor search.
//
// Search flow: an item is taken when start is high and busy is low. Each
// candidate pair (mul, add) passes a load state (ST_CAND), a division in
// the bit-serial divider and an evaluate step in ST_QWAIT. With mul =
// 1..15 there are up to 120 candidates, followed by two more divisions
// (recalculated baud, percent error); a zero-error hit ends the search
// early, and a search where no pair fits answers with an all-zero result
// and skips those two divisions. A baud rate of zero answers with an
// all-zero result and no search. All divisions use the one 64-step
// divider, so they run one after another. The result shows
// on the output ports for exactly one cycle with strobe_o high; there is no
// back-pressure, so the receiver must take it then. busy drops in the same
// cycle the strobe rises, so the next item can be started while the result
// is shown. sys_clock_hz is written through the cfg_* channel (always
// ready) and is sampled at item start.
`include "assert_macros.svh"

module fractional_baud_divisor_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fbd_pkg::SysClkW-1:0]   cfg_data_i,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [fbd_pkg::BaudW-1:0]     baud_rate_i,
  // result
  output logic                          strobe_o,
  output logic [15:0]                   divisor_latch_o,
  output logic [fbd_pkg::MulW-1:0]      mul_value_o,
  output logic [fbd_pkg::MulW-1:0]      add_value_o,
  output logic [7:0]                    error_percent_o,
  output logic                          accepted_o
);
  import fbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,    // launch division for current (mul, add)
    ST_QWAIT,   // wait for quotient, score the candidate
    ST_FINISH,  // launch baud recalculation or zero result
    ST_RWAIT,
    ST_PSTART,  // launch percent-error division
    ST_PWAIT
  } state_e;

  state_e             state_q;
  logic [SysClkW-1:0] sys_clk_q;
  logic [BaudW-1:0]   baud_q;
  logic [PclkW-1:0]   pclk_q;
  logic [MulW-1:0]    m_q;
  logic [MulW-1:0]    a_q;
  logic [31:0]        best_err_q;
  logic [DlW-1:0]     best_dl_q;
  logic [MulW-1:0]    best_m_q;
  logic [MulW-1:0]    best_a_q;
  logic               found_q;
  logic [PclkW-1:0]   diff_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // candidate operands
  logic [MulW:0]      ma_sum;
  logic [PclkW+MulW-1:0] cand_num;
  logic [28:0]        cand_den;
  // candidate scoring
  logic [31:0]        q_hi;
  logic [31:0]        q_frac;
  logic               round_up;
  logic [31:0]        cand_err;
  logic [32:0]        cand_dl;
  logic               cand_ok;
  logic               cand_better;
  logic               last_add;
  logic               last_mul;
  // recalculation operands
  logic [MulW:0]      best_ma;
  logic [PclkW-1:0]   rc_num;
  logic [21:0]        rc_den;
  logic [PclkW-1:0]   rc_val;
  logic [PclkW-1:0]   baud_ext;
  logic [36:0]        pct_num;
  logic [7:0]         pct_sat;
  logic               pct_ok;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  always_comb begin
    ma_sum   = {1'b0, m_q} + {1'b0, a_q};
    cand_num = (PclkW+MulW)'(pclk_q) * (PclkW+MulW)'(m_q);
    cand_den = 29'(baud_q) * 29'(ma_sum);

    // Q32 quotient: integer part is DL, fraction is the rounding error
    q_hi     = div_rsp.quotient[63:32];
    q_frac   = div_rsp.quotient[31:0];
    round_up = q_frac > HalfQ32;
    cand_err = round_up ? (32'd0 - q_frac) : q_frac;
    cand_dl  = {1'b0, q_hi} + {32'd0, round_up};
    cand_ok  = (cand_dl != '0) && (cand_dl <= 33'(DlMax));
    cand_better = cand_ok && (cand_err < best_err_q);
    last_add = ({1'b0, a_q} + 1'b1) == {1'b0, m_q};
    last_mul = (m_q == MulW'(MulMax));

    best_ma  = {1'b0, best_m_q} + {1'b0, best_a_q};
    rc_num   = PclkW'(pclk_q[PclkW-1:4]) * PclkW'(best_m_q);
    rc_den   = 22'(best_dl_q) * 22'(best_ma);
    rc_val   = div_rsp.quotient[PclkW-1:0];
    baud_ext = PclkW'(baud_q);
    pct_num  = 37'(diff_q) * 37'(PctScale);
    pct_sat  = (|div_rsp.quotient[63:8]) ? 8'hFF : div_rsp.quotient[7:0];
    pct_ok   = div_rsp.quotient < 64'(PctLimit);

    div_req = '0;
    case (state_q)
      ST_CAND: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(DivNumW-PclkW-MulW-FracShift){1'b0}}, cand_num,
                            {FracShift{1'b0}}};
        div_req.divisor  = DivDenW'(cand_den);
      end
      ST_FINISH: begin
        div_req.start    = found_q;
        div_req.dividend = DivNumW'(rc_num);
        div_req.divisor  = DivDenW'(rc_den);
      end
      ST_PSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivNumW'(pct_num);
        div_req.divisor  = DivDenW'(baud_q);
      end
      default: div_req = '0;
    endcase
  end

  fbd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sys_clk_q <= SysClkReset;
      strobe_o  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        sys_clk_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            if (baud_rate_i == '0) begin
              // nothing to search: all-zero result right away
              strobe_o        <= 1'b1;
              divisor_latch_o <= '0;
              mul_value_o     <= '0;
              add_value_o     <= '0;
              error_percent_o <= '0;
              accepted_o      <= 1'b0;
            end else begin
              baud_q     <= baud_rate_i;
              pclk_q     <= sys_clk_q[SysClkW-1:2];
              m_q        <= MulW'(1);
              a_q        <= '0;
              best_err_q <= ErrInit;
              found_q    <= 1'b0;
              state_q    <= ST_CAND;
            end
          end
        end
        ST_CAND: state_q <= ST_QWAIT;
        ST_QWAIT: begin
          if (div_rsp.done) begin
            if (cand_better) begin
              best_err_q <= cand_err;
              best_dl_q  <= cand_dl[DlW-1:0];
              best_m_q   <= m_q;
              best_a_q   <= a_q;
              found_q    <= 1'b1;
            end
            if ((cand_better && cand_err == '0) || (last_add && last_mul)) begin
              state_q <= ST_FINISH;
            end else begin
              if (last_add) begin
                m_q <= m_q + 1'b1;
                a_q <= '0;
              end else begin
                a_q <= a_q + 1'b1;
              end
              state_q <= ST_CAND;
            end
          end
        end
        ST_FINISH: begin
          if (found_q) begin
            state_q <= ST_RWAIT;
          end else begin
            strobe_o        <= 1'b1;
            divisor_latch_o <= '0;
            mul_value_o     <= '0;
            add_value_o     <= '0;
            error_percent_o <= '0;
            accepted_o      <= 1'b0;
            state_q         <= ST_IDLE;
          end
        end
        ST_RWAIT: begin
          if (div_rsp.done) begin
            diff_q  <= (baud_ext > rc_val) ? (baud_ext - rc_val) : (rc_val - baud_ext);
            state_q <= ST_PSTART;
          end
        end
        ST_PSTART: state_q <= ST_PWAIT;
        ST_PWAIT: begin
          if (div_rsp.done) begin
            strobe_o        <= 1'b1;
            divisor_latch_o <= best_dl_q[15:0];
            mul_value_o     <= best_m_q;
            add_value_o     <= best_a_q;
            error_percent_o <= pct_sat;
            accepted_o      <= pct_ok;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_acc_has_mul, clk_i, rst_ni, strobe_o && accepted_o, mul_value_o != '0)
  `ASSERT_IMPL(a_add_below_mul, clk_i, rst_ni, strobe_o && (mul_value_o != '0),
               add_value_o < mul_value_o)
  `ASSERT_IMPL(a_acc_low_err, clk_i, rst_ni, strobe_o && accepted_o, error_percent_o < 8'd3)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy && (baud_rate_i != '0), busy)

endmodule

// ===== sim/fractional_baud_divisor_search_top_test.sv =====
// Self-checking testbench for the fractional baud divisor search block.
module fractional_baud_divisor_search_top_test;
  import fbd_pkg::*;

  // A burst of silence this long means the block has hung: it outlasts the
  // slowest search and the longest sender gap.
  localparam int unsigned WatchdogLimit = 50000;
  // A quiet spell after the last result, to catch a stray strobe.
  localparam int unsigned TailCycles    = 100;
  localparam int unsigned RandPerPhase  = 19;
  localparam int unsigned NumRandPhases = 4;

  // One result item, as the block shows it on its result ports.
  typedef struct packed {
    logic [15:0]     divisor;
    logic [MulW-1:0] mul;
    logic [MulW-1:0] add;
    logic [7:0]      pct;
    logic            ok;
  } divisor_setting_t;

  // Keeps the divisor settings that the accepted baud rates call for, oldest
  // first, and checks each result item against the oldest one.
  class divisor_tracker;
    divisor_setting_t due[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int unsigned waiting();
      return due.size();
    endfunction

    // Search mul/add pairs for the divisor with the smallest rounding error,
    // then work out the real baud rate and the percent error.
    function divisor_setting_t predict_setting(bit [BaudW-1:0] baud, bit [SysClkW-1:0] sysclk);
      bit [63:0]        pclk, q, err, dl, best_err, best_dl, recalc, diff, pct;
      int unsigned      m, a, best_m, best_a;
      bit               found;
      divisor_setting_t r;
      r = '0;
      if (baud == 0) return r;
      pclk     = 64'(sysclk >> 2);
      best_err = 64'(ErrInit);
      best_dl  = 0;
      best_m   = 0;
      best_a   = 0;
      found    = 1'b0;
      for (m = 1; m <= MulMax && best_err != 0; m++) begin
        for (a = 0; a < m; a++) begin
          q   = (pclk * (64'd1 << FracShift) * 64'(m)) / (64'(baud) * 64'(m + a));
          err = q & 64'hFFFF_FFFF;
          dl  = q >> 32;
          // round to nearest: a fraction above one half rounds up
          if (err > 64'(HalfQ32)) begin
            err = 64'h1_0000_0000 - err;
            dl  = dl + 1;
          end
          if (dl < 1 || dl > 64'(DlMax)) continue;
          if (err < best_err) begin
            best_err = err;
            best_dl  = dl;
            best_m   = m;
            best_a   = a;
            found    = 1'b1;
            if (best_err == 0) break;
          end
        end
      end
      if (!found) return r;
      recalc = ((pclk >> 4) * 64'(best_m)) / (best_dl * 64'(best_m + best_a));
      recalc = recalc & 64'hFFFF_FFFF;
      diff   = (64'(baud) > recalc) ? 64'(baud) - recalc : recalc - 64'(baud);
      pct    = (diff * 64'(PctScale)) / 64'(baud);
      r.divisor = best_dl[15:0];
      r.mul     = best_m[MulW-1:0];
      r.add     = best_a[MulW-1:0];
      r.pct     = (pct > 255) ? 8'd255 : pct[7:0];
      r.ok      = (pct < 64'(PctLimit));
      return r;
    endfunction

    function void note_item(bit [BaudW-1:0] baud, bit [SysClkW-1:0] sysclk);
      due.push_back(predict_setting(baud, sysclk));
    endfunction

    task check_result(divisor_setting_t got);
      divisor_setting_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, dl=%0d", got.divisor));
        return;
      end
      want = due.pop_front();
      if (got.divisor !== want.divisor)
        report_mismatch($sformatf("divisor_latch %0d, want %0d", got.divisor, want.divisor));
      if (got.mul !== want.mul)
        report_mismatch($sformatf("mul_value %0d, want %0d", got.mul, want.mul));
      if (got.add !== want.add)
        report_mismatch($sformatf("add_value %0d, want %0d", got.add, want.add));
      if (got.pct !== want.pct)
        report_mismatch($sformatf("error_percent %0d, want %0d", got.pct, want.pct));
      if (got.ok !== want.ok)
        report_mismatch($sformatf("accepted %0b, want %0b", got.ok, want.ok));
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [SysClkW-1:0] cfg_data_i  = '0;
  logic               start       = 1'b0;
  logic               busy;
  logic [BaudW-1:0]   baud_rate_i = '0;
  logic               strobe_o;
  logic [15:0]        divisor_latch_o;
  logic [MulW-1:0]    mul_value_o;
  logic [MulW-1:0]    add_value_o;
  logic [7:0]         error_percent_o;
  logic               accepted_o;

  divisor_tracker     tracker;
  bit [SysClkW-1:0]   sys_clock_now = SysClkReset;  // setting the block holds now
  bit                 idle_on;                      // sender gaps enabled
  int unsigned        quiet_cycles = 0;

  // Directed rates under the reset clock (25 MHz peripheral clock):
  // zero rate, the field extremes, an exact hit (15625 -> DL 100, stops the
  // search early), common rates, alternating bit patterns.
  bit [BaudW-1:0] directed_rates [12] = '{
    24'd0, 24'd1, 24'd15625, 24'd9600, 24'd115200, 24'hFFFFFF,
    24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA, 24'd921600, 24'd300
  };

  bit [BaudW-1:0] std_rates [12] = '{
    24'd300, 24'd1200, 24'd2400, 24'd4800, 24'd9600, 24'd19200,
    24'd38400, 24'd57600, 24'd115200, 24'd230400, 24'd460800, 24'd921600
  };

  fractional_baud_divisor_search_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .baud_rate_i    (baud_rate_i),
    .strobe_o       (strobe_o),
    .divisor_latch_o(divisor_latch_o),
    .mul_value_o    (mul_value_o),
    .add_value_o    (add_value_o),
    .error_percent_o(error_percent_o),
    .accepted_o     (accepted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are strobed for one cycle and can't be held off, so every
  // strobe seen at an edge is checked right there.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      tracker.check_result({divisor_latch_o, mul_value_o, add_value_o,
                            error_percent_o, accepted_o});
  end

  // Watchdog: any item in, result out or register write resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Hold start with the rate until the block takes it. start stays high
  // afterwards so back-to-back items go without a gap.
  task automatic send_rate(input bit [BaudW-1:0] rate);
    start       <= 1'b1;
    baud_rate_i <= rate;
    do @(posedge clk_i); while (busy);
    tracker.note_item(rate, sys_clock_now);
  endtask

  // Random sender gap, about one time in three while gaps are enabled.
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stop sending until every pending result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.waiting() != 0);
  endtask

  // Only called with the block idle: after reset or after a drain.
  task automatic write_sys_clock(input bit [SysClkW-1:0] hz);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    sys_clock_now = hz;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly standard rates and rates near an exact divisor of the current
  // clock, with full-range and very low rates mixed in.
  function automatic bit [BaudW-1:0] pick_rate();
    bit [63:0] pclk, v;
    int unsigned sel;
    pclk = 64'(sys_clock_now >> 2);
    sel  = $urandom_range(0, 9);
    if (sel < 4) return std_rates[$urandom_range(0, 11)];
    if (sel < 6) begin
      v = pclk / (64'd16 * 64'($urandom_range(1, DlMax)));
      if (v != 0 && v < (64'd1 << BaudW)) return v[BaudW-1:0];
    end
    if (sel == 6) return BaudW'($urandom_range(1, 2000));
    return BaudW'($urandom);
  endfunction

  task automatic run_phase(input bit [SysClkW-1:0] hz, input bit [BaudW-1:0] rates[$]);
    drain();
    write_sys_clock(hz);
    foreach (rates[i]) begin
      send_rate(rates[i]);
      maybe_idle();
    end
  endtask

  initial begin
    bit [SysClkW-1:0] hz;
    tracker = new();
    idle_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset clock written explicitly.
    write_sys_clock(SysClkReset);
    foreach (directed_rates[i]) begin
      send_rate(directed_rates[i]);
      maybe_idle();
    end
    // pclk = 2^20: rate 1 gives DL exactly 65536, which wraps to 0.
    run_phase(32'd4194304, '{24'd1, 24'd2, 24'd0, 24'hFFFFFF});
    // Tiny clocks: peripheral clock 0 or 1, no pair fits.
    run_phase(32'd1, '{24'd9600, 24'd0});
    run_phase(32'd3, '{24'd1});
    run_phase(32'd4, '{24'd1, 24'hFFFFFF});
    // Largest clock.
    run_phase(32'hFFFF_FFFF, '{24'hFFFFFF, 24'd1, 24'd115200});

    // Random part, one clock setting per phase; the last phase runs flat out.
    for (int p = 0; p < NumRandPhases; p++) begin
      case (p)
        0: hz = 32'd58982400;
        1: hz = 32'hFFFF_FFFF;
        2: begin
          hz = $urandom;
          if (hz == 0) hz = 1;
        end
        default: hz = SysClkReset;
      endcase
      idle_on = (p != NumRandPhases - 1);
      drain();
      write_sys_clock(hz);
      for (int i = 0; i < RandPerPhase; i++) begin
        send_rate(pick_rate());
        if (idle_on && $urandom_range(0, 15) == 0) drain();
        else maybe_idle();
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.waiting() != 0)
      tracker.report_mismatch($sformatf("%0d results never came", tracker.waiting()));
    if (tracker.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
